// File: rtl/pipt_pkg.sv
// Shared types and constants for the point-in-polygon ray casting block.
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

    localparam int COORD_W = 14;
    localparam int CNT_W   = 5;
    localparam int VIDX_W  = 4;

    // The ray runs from the query point to this x at the same y.
    localparam logic [COORD_W-1:0] RAY_END_X = 14'd10000;

    // Fewer in-use vertices than this give outside.
    localparam int MIN_VERTICES = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch query point, clear accumulators
        logic store;     // write one vertex from the input word
        logic rd_en;     // read one vertex from the store
        logic first;     // this read opens the walk, no edge yet
        logic load_out;  // capture the answer in the output register
    } pipt_cmd_t;

endpackage

`default_nettype wire

// File: rtl/pipt_ctrl.sv
// Controller: handshakes, vertex count register and the edge walk sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pipt_ctrl #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        operation,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    input  wire logic                        cfg_wr_en,
    input  wire logic [pipt_pkg::CNT_W-1:0]  cfg_wr_data,
    output pipt_pkg::pipt_cmd_t              cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]  rd_addr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int NW = (CW > pipt_pkg::CNT_W) ? CW : pipt_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic [NW-1:0]               k_reg, k_next;
    logic                        drain_reg, drain_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pipt_pkg::CNT_W-1:0]  vertex_count_reg, vertex_count_next;

    logic [NW-1:0] cnt_ext;
    logic [NW-1:0] n_eff;

    // A count above the store capacity is used as the capacity.
    assign cnt_ext = NW'(vertex_count_reg);
    assign n_eff   = (cnt_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : cnt_ext;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        drain_next        = drain_reg;
        vertex_count_next = cfg_wr_en ? cfg_wr_data : vertex_count_reg;
        cmd               = '0;
        rd_addr           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == pipt_pkg::OP_QUERY)
                    begin
                        cmd.start = 1'b1;
                        k_next    = '0;
                        // Too few vertices: accumulators stay clear, answer is outside.
                        state_next = (n_eff < NW'(pipt_pkg::MIN_VERTICES)) ?
                                     ST_FINISH : ST_WALK;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                // Reads vertices 0..n-1 and then vertex 0 again to close the polygon.
                cmd.rd_en = 1'b1;
                cmd.first = (k_reg == '0);
                rd_addr   = (k_reg == n_eff) ? '0 : k_reg[AW-1:0];
                if (k_reg == n_eff)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
                else
                begin
                    k_next = k_reg + NW'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            k_reg            <= '0;
            drain_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            drain_reg        <= drain_next;
            out_valid_reg    <= out_valid_next;
            vertex_count_reg <= vertex_count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pipt_dp.sv
// Datapath: vertex store, two-stage edge crossing unit and answer accumulators.
`timescale 1ns / 1ps
`default_nettype none

module pipt_dp #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pipt_pkg::pipt_cmd_t           cmd,
    input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  wire logic [pipt_pkg::VIDX_W-1:0]   vertex_index,
    input  wire logic [pipt_pkg::COORD_W-1:0]  coord_x,
    input  wire logic [pipt_pkg::COORD_W-1:0]  coord_y,
    output logic                               inside_res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int IW = (AW + 1 > pipt_pkg::VIDX_W) ? AW + 1 : pipt_pkg::VIDX_W;
    localparam int CWD = pipt_pkg::COORD_W;

    typedef enum logic [1:0] {
        ORI_COL,
        ORI_CW,
        ORI_CCW
    } orient_t;

    typedef logic [CWD-1:0] coord_t;

    function automatic logic in_box(coord_t qx, coord_t qy,
                                    coord_t ex0, coord_t ey0,
                                    coord_t ex1, coord_t ey1);
        logic okx;
        logic oky;
        okx = ((qx >= ex0) && (qx <= ex1)) || ((qx >= ex1) && (qx <= ex0));
        oky = ((qy >= ey0) && (qy <= ey1)) || ((qy >= ey1) && (qy <= ey0));
        return okx && oky;
    endfunction

    // Orientation of p, r and a vertex, where p and r share y: the value is
    // the negated product of the two differences, so only signs matter.
    function automatic orient_t ray_orient(logic signed [CWD:0] d,
                                           logic signed [CWD:0] e);
        orient_t o;
        if ((d == '0) || (e == '0))
        begin
            o = ORI_COL;
        end
        else if (d[CWD] != e[CWD])
        begin
            o = ORI_CW;
        end
        else
        begin
            o = ORI_CCW;
        end
        return o;
    endfunction

    function automatic orient_t val_orient(logic signed [2*CWD+2:0] v);
        orient_t o;
        if (v == '0)
        begin
            o = ORI_COL;
        end
        else if (!v[2*CWD+2])
        begin
            o = ORI_CW;
        end
        else
        begin
            o = ORI_CCW;
        end
        return o;
    endfunction

    // Vertex store, x in the low half and y in the high half.
    logic [2*CWD-1:0] mem [MAX_VERTICES];
    logic [2*CWD-1:0] rd_data_reg;

    logic [IW-1:0] idx_ext;
    logic          wr_ok;

    assign idx_ext = IW'(vertex_index);
    assign wr_ok   = cmd.store && (idx_ext < IW'(MAX_VERTICES));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[idx_ext[AW-1:0]] <= {coord_y, coord_x};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control pipeline.
    logic s1_vld_reg, s1_edge_reg, s2_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_edge_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= cmd.rd_en;
            s1_edge_reg <= cmd.rd_en && !cmd.first;
            s2_vld_reg  <= s1_edge_reg;
        end
    end

    // Query point.
    coord_t qx_reg, qy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
    end

    // Stage 1: edge from the previous vertex a to the vertex just read b.
    coord_t prev_x_reg, prev_y_reg;
    coord_t ax, ay, bx, by;
    logic signed [CWD:0] dyab, dxab, dxpb, dxrb, dypb;
    logic signed [2*CWD+1:0] m1, m2, m3;

    assign ax = prev_x_reg;
    assign ay = prev_y_reg;
    assign bx = rd_data_reg[CWD-1:0];
    assign by = rd_data_reg[2*CWD-1:CWD];

    assign dyab = $signed({1'b0, by}) - $signed({1'b0, ay});
    assign dxab = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign dxpb = $signed({1'b0, qx_reg}) - $signed({1'b0, bx});
    assign dxrb = $signed({1'b0, pipt_pkg::RAY_END_X}) - $signed({1'b0, bx});
    assign dypb = $signed({1'b0, qy_reg}) - $signed({1'b0, by});

    assign m1 = dyab * dxpb;
    assign m2 = dyab * dxrb;
    assign m3 = dxab * dypb;

    logic signed [2*CWD+1:0] m1_reg, m2_reg, m3_reg;
    coord_t s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prev_x_reg <= bx;
            prev_y_reg <= by;
        end
        if (s1_edge_reg)
        begin
            m1_reg    <= m1;
            m2_reg    <= m2;
            m3_reg    <= m3;
            s2_ax_reg <= ax;
            s2_ay_reg <= ay;
            s2_bx_reg <= bx;
            s2_by_reg <= by;
        end
    end

    // Stage 2: four orientations and the crossing decision.
    logic signed [2*CWD+2:0] v1, v2;
    logic signed [CWD:0]     drp, eya, eyb;
    orient_t o1, o2, o3, o4;
    logic    p_on_box, r_on_box, a_on_ray, b_on_ray;
    logic    edge_hit;

    assign v1 = $signed({m1_reg[2*CWD+1], m1_reg}) - $signed({m3_reg[2*CWD+1], m3_reg});
    assign v2 = $signed({m2_reg[2*CWD+1], m2_reg}) - $signed({m3_reg[2*CWD+1], m3_reg});

    assign drp = $signed({1'b0, pipt_pkg::RAY_END_X}) - $signed({1'b0, qx_reg});
    assign eya = $signed({1'b0, s2_ay_reg}) - $signed({1'b0, qy_reg});
    assign eyb = $signed({1'b0, s2_by_reg}) - $signed({1'b0, qy_reg});

    assign o1 = val_orient(v1);
    assign o2 = val_orient(v2);
    assign o3 = ray_orient(drp, eya);
    assign o4 = ray_orient(drp, eyb);

    assign p_on_box = in_box(qx_reg, qy_reg, s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg);
    assign r_on_box = in_box(pipt_pkg::RAY_END_X, qy_reg,
                             s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg);
    assign a_on_ray = in_box(s2_ax_reg, s2_ay_reg, qx_reg, qy_reg,
                             pipt_pkg::RAY_END_X, qy_reg);
    assign b_on_ray = in_box(s2_bx_reg, s2_by_reg, qx_reg, qy_reg,
                             pipt_pkg::RAY_END_X, qy_reg);

    assign edge_hit = ((o1 != o2) && (o3 != o4)) ||
                      ((o1 == ORI_COL) && p_on_box) ||
                      ((o2 == ORI_COL) && r_on_box) ||
                      ((o3 == ORI_COL) && a_on_ray) ||
                      ((o4 == ORI_COL) && b_on_ray);

    // The first crossed edge that is collinear with the point settles the
    // answer; otherwise the parity of crossed edges does.
    logic hit_reg, dec_reg, dval_reg, inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            dec_reg  <= 1'b0;
            dval_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            hit_reg  <= 1'b0;
            dec_reg  <= 1'b0;
            dval_reg <= 1'b0;
        end
        else if (s2_vld_reg && !dec_reg && edge_hit)
        begin
            if (o1 == ORI_COL)
            begin
                dec_reg  <= 1'b1;
                dval_reg <= p_on_box;
            end
            else
            begin
                hit_reg <= !hit_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            inside_reg <= dec_reg ? dval_reg : hit_reg;
        end
    end

    assign inside_res = inside_reg;

endmodule

`default_nettype wire

// File: rtl/point_in_polygon_test.sv
// Top level of the ray casting point-in-polygon test.
//
//  port group   direction  handshake            word
//  in           in         in_valid/in_ready    operation, vertex_index, coord_x, coord_y
//  out          out        out_valid/out_ready  inside_res
//  cfg          in         cfg_wr_en            cfg_wr_data (vertex count)
//
// Loads are taken back to back. A query with n >= 3 vertices in use reads n + 1
// vertices through the single store read port, one edge a cycle, then the two-stage
// crossing unit drains and the finish step loads the result; the next word is taken
// after that. With fewer than three vertices the walk is skipped and the block goes
// straight to its finish step. Reset clears control state and the vertex count; the
// vertex store is not cleared. A result waiting on out_ready holds the block in its
// finish step once the next query is done; loads are still taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic [pipt_pkg::VIDX_W-1:0]   vertex_index,
    input  wire logic [pipt_pkg::COORD_W-1:0]  coord_x,
    input  wire logic [pipt_pkg::COORD_W-1:0]  coord_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               inside_res,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pipt_pkg::CNT_W-1:0]    cfg_wr_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    pipt_pkg::pipt_cmd_t cmd;
    logic [AW-1:0]       rd_addr;

    pipt_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    pipt_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .inside_res   (inside_res)
    );

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register overwritten while pending");

    // No word is taken while the edge walk is reading the store.
    a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !in_ready)
        else $error("input ready during edge walk");

    // Store reads stay within capacity.
    a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (int'(rd_addr) < MAX_VERTICES))
        else $error("store read address beyond capacity");

    // A query start is followed by the walk or the finish, never another start.
    a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !cmd.start && !in_ready)
        else $error("query start not followed by work");

endmodule

`default_nettype wire
